/* src/kdef_pkg.sv */
// shared types and constants of the key debounce event fifo
package kdef_pkg;

   localparam logic [1:0]  FUNC_TICK      = 2'd0;
   localparam logic [1:0]  FUNC_EDGE      = 2'd1;
   localparam logic [1:0]  FUNC_POP       = 2'd2;
   localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
   localparam logic [6:0]  COUNT_MAX      = 7'd127;

   typedef struct packed {
      logic [1:0] func;
      logic [2:0] key_index;
      logic       key_level;
   } req_type;

   typedef struct packed {
      logic       event_valid;
      logic [2:0] event_key;
      logic       event_level;
      logic [6:0] fifo_count;
      logic       overflow_seen;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_EDGE = 2'd1,
      OP_POP  = 2'd2,
      OP_NOP  = 2'd3
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] key_index;
      logic       key_level;
   } cmd_type;

endpackage

/* src/key_debounce_event_fifo.sv */
// top level of the key debouncer with event fifo
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   request | req_valid, req_stall, req_data | in
//   result  | rsp_valid, rsp_stall, rsp_data | out
//   config  | csr_write_en, csr_write_data   | in
//
// edge, nop and empty pop: result registered from S_IDLE; pop with data goes through S_POP (ram read)
// tick: S_SCAN takes the expiring keys in turn, one fifo push per cycle while the fifo is not full
// the next command is taken the cycle after the previous result leaves the output register
// a two-entry command queue decouples acceptance from the back end
// reset clears timers, pointers and flags; the event ram is not cleared
// results wait in an output register while rsp_stall is high
module key_debounce_event_fifo
   import kdef_pkg::*;
#(
   parameter int NUM_KEYS   = 8,
   parameter int FIFO_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data
);

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;

   kdef_front #(
      .NUM_KEYS(NUM_KEYS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   kdef_back #(
      .NUM_KEYS   (NUM_KEYS),
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_take       (cmd_take),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data)
   );

endmodule

/* src/kdef_ram.sv */
// generic single write port ram with registered read
module kdef_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/kdef_front.sv */
// front end: accepts items, decodes them and queues commands
module kdef_front
   import kdef_pkg::*;
#(
   parameter int NUM_KEYS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_take
);

   cmd_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept;
   logic [5:0] key_wide;
   cmd_type    decoded;

   assign req_stall = (count_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign key_wide  = 6'(req_data.key_index);

   always_comb begin
      decoded.key_index = req_data.key_index;
      decoded.key_level = req_data.key_level;
      case (req_data.func)
         FUNC_TICK: decoded.op = OP_TICK;
         FUNC_EDGE: decoded.op = (key_wide < 6'(NUM_KEYS)) ? OP_EDGE : OP_NOP;
         FUNC_POP:  decoded.op = OP_POP;
         default:   decoded.op = OP_NOP;
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (cmd_take) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (accept && !cmd_take) begin
         count_in = count_ff + 2'd1;
      end else if (!accept && cmd_take) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];

endmodule

/* src/kdef_back.sv */
// back end: key timers, event fifo and result register
module kdef_back
   import kdef_pkg::*;
#(
   parameter int NUM_KEYS   = 8,
   parameter int FIFO_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_take,
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int PTR_W = $clog2(FIFO_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_POP  = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [15:0]          ticks_ff;
   logic [15:0]          countdown_ff [NUM_KEYS];
   logic [15:0]          countdown_in [NUM_KEYS];
   logic [NUM_KEYS-1:0]  running_ff, running_in;
   logic [NUM_KEYS-1:0]  latched_ff, latched_in;
   logic [NUM_KEYS-1:0]  mask_ff, mask_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     count_ff, count_in;
   logic                 dropped_ff, dropped_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic                 full;
   logic [KEY_W-1:0]     low_key;
   logic [4:0]           low_key_wide;
   logic [KEY_W-1:0]     edge_key;
   logic [15:0]          reload;
   logic                 ram_wr_en;
   logic [3:0]           ram_wr_data;
   logic                 ram_rd_en;
   logic [3:0]           ram_rd_data;
   logic [PTR_W+6:0]     count_wide;
   logic [6:0]           count_sat;
   logic [15:0]          dec;

   assign full         = (count_ff == PTR_W'(FIFO_DEPTH - 1));
   assign edge_key     = KEY_W'(cmd.key_index);
   assign reload       = (ticks_ff == 16'd0) ? 16'd1 : ticks_ff;
   assign count_wide   = (PTR_W + 7)'(count_ff);
   assign count_sat    = (count_wide > (PTR_W + 7)'(COUNT_MAX)) ? COUNT_MAX : count_wide[6:0];
   assign low_key_wide = 5'(low_key);
   assign ram_wr_data  = {low_key_wide[2:0], latched_ff[low_key]};

   // lowest expired key goes first
   always_comb begin
      low_key = '0;
      for (int k = NUM_KEYS - 1; k >= 0; k--) begin
         if (mask_ff[k]) begin
            low_key = KEY_W'(k);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      countdown_in = countdown_ff;
      running_in   = running_ff;
      latched_in   = latched_ff;
      mask_in      = mask_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cmd_take     = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      dec          = '0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !rsp_valid_ff) begin
               cmd_take                  = 1'b1;
               rsp_data_in.event_valid   = 1'b0;
               rsp_data_in.event_key     = 3'd0;
               rsp_data_in.event_level   = 1'b0;
               rsp_data_in.fifo_count    = count_sat;
               rsp_data_in.overflow_seen = dropped_ff;
               case (cmd.op)
                  OP_TICK: begin
                     for (int k = 0; k < NUM_KEYS; k++) begin
                        mask_in[k] = 1'b0;
                        if (running_ff[k]) begin
                           dec = (countdown_ff[k] != 16'd0) ? countdown_ff[k] - 16'd1
                                                            : countdown_ff[k];
                           countdown_in[k] = dec;
                           if (dec == 16'd0) begin
                              running_in[k] = 1'b0;
                              mask_in[k]    = 1'b1;
                           end
                        end
                     end
                     state_in = S_SCAN;
                  end
                  OP_EDGE: begin
                     latched_in[edge_key]   = cmd.key_level;
                     countdown_in[edge_key] = reload;
                     running_in[edge_key]   = 1'b1;
                     rsp_valid_in           = 1'b1;
                  end
                  OP_POP: begin
                     if (count_ff != '0) begin
                        ram_rd_en = 1'b1;
                        rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                          : rd_ptr_ff + 1'b1;
                        count_in  = count_ff - 1'b1;
                        state_in  = S_POP;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (mask_ff == '0) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.fifo_count    = count_sat;
               rsp_data_in.overflow_seen = dropped_ff;
               state_in                  = S_IDLE;
            end else begin
               mask_in[low_key] = 1'b0;
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  ram_wr_en = 1'b1;
                  wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
                  count_in  = count_ff + 1'b1;
               end
            end
         end
         S_POP: begin
            rsp_valid_in              = 1'b1;
            rsp_data_in.event_valid   = 1'b1;
            rsp_data_in.event_key     = ram_rd_data[3:1];
            rsp_data_in.event_level   = ram_rd_data[0];
            rsp_data_in.fifo_count    = count_sat;
            rsp_data_in.overflow_seen = dropped_ff;
            state_in                  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ticks_ff     <= DEBOUNCE_RESET;
         running_ff   <= '0;
         latched_ff   <= '0;
         mask_ff      <= '0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            countdown_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         latched_ff   <= latched_in;
         mask_ff      <= mask_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
         countdown_ff <= countdown_in;
         if (csr_write_en) begin
            ticks_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   kdef_ram #(
      .WIDTH(4),
      .DEPTH(FIFO_DEPTH)
   ) u_event_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= PTR_W'(FIFO_DEPTH - 1))
      else $error("event count beyond ring capacity");

   a_take_free: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> !rsp_valid_ff && (state_ff == S_IDLE))
      else $error("command taken while result pending");

   a_scan_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) && (mask_ff == '0) |=> (state_ff == S_IDLE) && rsp_valid_ff)
      else $error("tick scan did not finish with a result");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) && (mask_ff != '0) && full |=> $stable(wr_ptr_ff) && dropped_ff)
      else $error("push on full ring not dropped");

   a_pop_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |=> rsp_valid_ff && rsp_data_ff.event_valid)
      else $error("pop did not return an event");
`endif

endmodule
